// File: design/hce_pkg.sv
package hce_pkg;

  localparam int FINEST_LEVEL_DEFAULT = 15;

  localparam int CELL_W  = 64;
  localparam int LEVEL_W = 4;
  localparam int DIGIT_W = 3;
  localparam int RES_LSB = 52;

  // Digit codes that the child walk cares about
  localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 3'd0;
  localparam logic [DIGIT_W-1:0] DIGIT_LAST = 3'd6;
  localparam logic [DIGIT_W-1:0] DIGIT_SKIP = 3'd2;

  // Start or step selector
  localparam logic KIND_START = 1'b0;

  // A skip level of zero never matches a digit level, so it stands for "no skip".
  typedef struct packed {
    logic [CELL_W-1:0]  current_cell;
    logic [LEVEL_W-1:0] parent_level;
    logic [LEVEL_W-1:0] skip_position;
  } walk_state_t;

endpackage

// File: design/hce_ifs.sv
interface hce_item_if
  import hce_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CELL_W-1:0]  parent_index;
  logic [LEVEL_W-1:0] child_res;
  logic               pentagon_parent;

  modport source (output valid, kind, parent_index, child_res, pentagon_parent,
                  input ready);
  modport sink (input valid, kind, parent_index, child_res, pentagon_parent,
                output ready);
endinterface

interface hce_result_if
  import hce_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] child_index;
  logic              done_res;

  modport source (output valid, child_index, done_res, input ready);
  modport sink (input valid, child_index, done_res, output ready);
endinterface

// File: design/hce_next_state.sv
module hce_next_state
  import hce_pkg::*;
#(
  parameter int FINEST_LEVEL = FINEST_LEVEL_DEFAULT
) (
  input  logic               kind,
  input  logic [CELL_W-1:0]  parent_index,
  input  logic [LEVEL_W-1:0] child_res,
  input  logic               pentagon_parent,
  input  walk_state_t        state,
  output walk_state_t        state_next
);

  localparam logic [LEVEL_W-1:0] FINEST = LEVEL_W'(FINEST_LEVEL);

  logic [LEVEL_W-1:0] parent_res;
  logic               start_ok;
  logic [CELL_W-1:0]  start_cell;

  logic [LEVEL_W-1:0] cur_res;
  logic               carry_in [0:FINEST_LEVEL];
  logic               exhausted;
  logic               skipped;
  logic [CELL_W-1:0]  step_cell;

  // Start: clear the digits between parent and child resolution, set the new resolution.
  always_comb begin
    parent_res = parent_index[RES_LSB +: LEVEL_W];
    start_ok   = (parent_index != '0) && (child_res >= parent_res) && (child_res <= FINEST);
    start_cell = parent_index;
    for (int r = 1; r <= FINEST_LEVEL; r++) begin
      if ((LEVEL_W'(r) > parent_res) && (LEVEL_W'(r) <= child_res)) begin
        start_cell[DIGIT_W*(FINEST_LEVEL-r) +: DIGIT_W] = DIGIT_ZERO;
      end
    end
    start_cell[RES_LSB +: LEVEL_W] = child_res;
  end

  // Step: carry enters at the child level and ripples up through every digit at its last value.
  always_comb begin
    cur_res = state.current_cell[RES_LSB +: LEVEL_W];
    carry_in[FINEST_LEVEL] = (cur_res == FINEST);
    for (int i = FINEST_LEVEL - 1; i >= 0; i--) begin
      carry_in[i] = (cur_res == LEVEL_W'(i)) ||
                    ((LEVEL_W'(i) < cur_res) && carry_in[i+1] &&
                     (state.current_cell[DIGIT_W*(FINEST_LEVEL-i-1) +: DIGIT_W] == DIGIT_LAST));
    end
    exhausted = 1'b0;
    for (int i = 0; i <= FINEST_LEVEL; i++) begin
      if ((state.parent_level == LEVEL_W'(i)) && carry_in[i]) begin
        exhausted = 1'b1;
      end
    end
  end

  always_comb begin : digit_update
    logic [DIGIT_W-1:0] d;
    step_cell = state.current_cell;
    skipped   = 1'b0;
    d         = DIGIT_ZERO;
    for (int r = 1; r <= FINEST_LEVEL; r++) begin
      d = state.current_cell[DIGIT_W*(FINEST_LEVEL-r) +: DIGIT_W];
      if ((LEVEL_W'(r) > state.parent_level) && carry_in[r]) begin
        // Pentagon: pass over the first digit value one at the skip level
        if ((state.skip_position == LEVEL_W'(r)) && (d == DIGIT_ZERO)) begin
          step_cell[DIGIT_W*(FINEST_LEVEL-r) +: DIGIT_W] = DIGIT_SKIP;
          skipped = 1'b1;
        end else if (d == DIGIT_LAST) begin
          step_cell[DIGIT_W*(FINEST_LEVEL-r) +: DIGIT_W] = DIGIT_ZERO;
        end else begin
          step_cell[DIGIT_W*(FINEST_LEVEL-r) +: DIGIT_W] = d + DIGIT_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (kind == KIND_START) begin
      if (start_ok) begin
        state_next.current_cell  = start_cell;
        state_next.parent_level  = parent_res;
        state_next.skip_position = pentagon_parent ? child_res : '0;
      end else begin
        state_next = '0;
      end
    end else if (state.current_cell == '0) begin
      state_next = state;
    end else if (exhausted || (cur_res > FINEST)) begin
      state_next = '0;
    end else begin
      state_next.current_cell  = step_cell;
      state_next.parent_level  = state.parent_level;
      state_next.skip_position = skipped ? (state.skip_position - LEVEL_W'(1))
                                         : state.skip_position;
    end
  end

endmodule

// File: design/hier_cell_child_enumerator_unit.sv
// Child cell enumerator for a hierarchical hexagonal cell index.
//
// Channels: item (sink) takes a start or a step; result (source) returns one
// child index per item, with done_res set when the index is zero. A start
// loads the parent index, the child resolution and the pentagon flag; a bad
// start (null parent, child resolution below the parent's or above the finest
// level) answers zero with done_res set. Each step returns the next child, or zero once the walk ends.
//
// The result is valid in the cycle after the item transfer.
// Throughput: one item per cycle while the receiver takes each result. The walk state doubles as the result
// register; its next value comes from one combinational pass whose longest
// path is the carry ripple across the fifteen 3-bit digits.
//
// Reset clears the walk to null and drops result valid; the block accepts
// items in the first cycle after reset. When the receiver stalls, the
// result holds and item ready stays high only while the held result is
// taken in the same cycle.
module hier_cell_child_enumerator_unit
  import hce_pkg::*;
#(
  parameter int FINEST_LEVEL = FINEST_LEVEL_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  hce_item_if.sink       item,
  hce_result_if.source   result
);

  walk_state_t state;
  walk_state_t state_next;
  logic        out_valid;
  logic        take;

  assign item.ready = !out_valid || result.ready;
  assign take       = item.valid && item.ready;

  hce_next_state #(
    .FINEST_LEVEL (FINEST_LEVEL)
  ) u_next (
    .kind            (item.kind),
    .parent_index    (item.parent_index),
    .child_res       (item.child_res),
    .pentagon_parent (item.pentagon_parent),
    .state           (state),
    .state_next      (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.child_index = state.current_cell;
  assign result.done_res    = (state.current_cell == '0);

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> result.valid)
    else $error("accepted item left no result");

  a_null_step_stays_null: assert property (@(posedge clk) disable iff (rst)
    (take && item.kind != KIND_START && state.current_cell == '0) |=>
      (state.current_cell == '0))
    else $error("step from null produced a cell");

  a_null_start_done: assert property (@(posedge clk) disable iff (rst)
    (take && item.kind == KIND_START && item.parent_index == '0) |=> result.done_res)
    else $error("null parent start not reported done");

  a_step_keeps_res: assert property (@(posedge clk) disable iff (rst)
    (take && item.kind != KIND_START && state.current_cell != '0) |=>
      ((state.current_cell == '0) ||
       (state.current_cell[RES_LSB +: LEVEL_W] ==
        $past(state.current_cell[RES_LSB +: LEVEL_W]))))
    else $error("step changed the resolution field");

  a_skip_in_range: assert property (@(posedge clk) disable iff (rst)
    (state.current_cell != '0) |->
      ((state.skip_position <= state.current_cell[RES_LSB +: LEVEL_W]) &&
       (state.parent_level <= state.current_cell[RES_LSB +: LEVEL_W])))
    else $error("skip or parent level beyond child resolution");

endmodule

// File: bench/hier_cell_child_enumerator_unit_tb.sv
module hier_cell_child_enumerator_unit_tb
  import hce_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOP_LEVEL = FINEST_LEVEL_DEFAULT;
  localparam int NO_LEVEL = -1;
  localparam logic KIND_STEP = ~KIND_START;
  localparam logic [DIGIT_W-1:0] DIGIT_ONE = 3'd1;
  localparam logic [DIGIT_W-1:0] DIGIT_WRAP = 3'd7;
  localparam int LIVE_ITEMS = 1600;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT = 150000;

  typedef struct {
    logic [CELL_W-1:0] child;
    logic              done;
  } child_expect_t;

  class child_walk_scoreboard;
    logic [CELL_W-1:0] walk_cell;
    int                walk_parent_lvl;
    int                walk_skip_lvl;
    child_expect_t     child_q[$];
    int                errors;
    int                live_items;

    function new();
      clear_walk();
      errors = 0;
      live_items = 0;
    endfunction

    static function int unsigned digit_lsb(int lvl);
      int s;
      s = DIGIT_W * (TOP_LEVEL - lvl);
      if (s < 0 || s > 60) return 0;
      return s;
    endfunction

    function void clear_walk();
      walk_cell = '0;
      walk_parent_lvl = NO_LEVEL;
      walk_skip_lvl = NO_LEVEL;
    endfunction

    function void bump_digit(int lvl);
      walk_cell = walk_cell + (64'd1 << digit_lsb(lvl));
    endfunction

    function void advance_walk();
      int child;
      int i;
      child = int'(walk_cell[RES_LSB +: LEVEL_W]);
      if (child > TOP_LEVEL) begin
        clear_walk();
        return;
      end
      bump_digit(child);
      // ripple the carry toward the parent; reaching the parent digit ends the walk
      for (i = child; i >= walk_parent_lvl; i--) begin
        if (i == walk_parent_lvl || i < 1) begin
          clear_walk();
          return;
        end
        if (i == walk_skip_lvl && walk_cell[digit_lsb(i) +: DIGIT_W] == DIGIT_ONE) begin
          bump_digit(i);
          walk_skip_lvl--;
          return;
        end
        if (walk_cell[digit_lsb(i) +: DIGIT_W] == DIGIT_WRAP) bump_digit(i);
        else break;
      end
    endfunction

    function void note_item(logic kind, logic [CELL_W-1:0] parent, logic [LEVEL_W-1:0] cres,
                            logic pent);
      int pres;
      int r;
      logic [CELL_W-1:0] c;
      child_expect_t e;
      if (kind == KIND_START) begin
        live_items++;
        pres = int'(parent[RES_LSB +: LEVEL_W]);
        if (parent == '0 || int'(cres) < pres || int'(cres) > TOP_LEVEL) begin
          clear_walk();
        end else begin
          c = parent;
          for (r = pres + 1; r <= int'(cres); r++) c[digit_lsb(r) +: DIGIT_W] = '0;
          c[RES_LSB +: LEVEL_W] = cres;
          walk_cell = c;
          walk_parent_lvl = pres;
          walk_skip_lvl = pent ? int'(cres) : NO_LEVEL;
        end
      end else if (walk_cell != '0) begin
        live_items++;
        advance_walk();
      end
      e.child = walk_cell;
      e.done = (walk_cell == '0);
      child_q.push_back(e);
    endfunction

    task report_mismatch(string what, logic [CELL_W-1:0] got, logic [CELL_W-1:0] want);
      $display("MISMATCH %0s: got %h, want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [CELL_W-1:0] child, logic done);
      child_expect_t e;
      if (child_q.size() == 0) begin
        report_mismatch("result with no item pending", child, '0);
      end else begin
        e = child_q.pop_front();
        if (child !== e.child) report_mismatch("child_index", child, e.child);
        if (done !== e.done) report_mismatch("done_res", 64'(done), 64'(e.done));
      end
    endtask

    function int pending();
      return child_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  hce_item_if item_ch ();
  hce_result_if result_ch ();

  hier_cell_child_enumerator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  child_walk_scoreboard walk_sb;
  int src_idle_pct = 32;
  int sink_idle_pct = 32;
  int hold_off_reqs = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        walk_sb.note_item(item_ch.kind, item_ch.parent_index, item_ch.child_res,
                          item_ch.pentagon_parent);
      if (result_ch.valid && result_ch.ready)
        walk_sb.check_result(result_ch.child_index, result_ch.done_res);
    end
  end

  // receiver: random stalls, plus a long hold-off on each request
  initial begin
    int hold_off_seen;
    hold_off_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_seen != hold_off_reqs) begin
        hold_off_seen = hold_off_reqs;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic logic [CELL_W-1:0] make_parent(int lvl);
    logic [CELL_W-1:0] p;
    int r;
    p = {$urandom, $urandom};
    p[RES_LSB +: LEVEL_W] = LEVEL_W'(lvl);
    // half the parents carry the usual unused-digit filler
    if ($urandom_range(0, 1))
      for (r = lvl + 1; r <= TOP_LEVEL; r++)
        p[child_walk_scoreboard::digit_lsb(r) +: DIGIT_W] = DIGIT_WRAP;
    return p;
  endfunction

  task automatic send_item(logic kind, logic [CELL_W-1:0] parent, logic [LEVEL_W-1:0] cres,
                           logic pent);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= kind;
    item_ch.parent_index <= parent;
    item_ch.child_res <= cres;
    item_ch.pentagon_parent <= pent;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_step();
    send_item(KIND_STEP, {$urandom, $urandom}, LEVEL_W'($urandom), 1'($urandom));
  endtask

  task automatic send_steps(int n);
    repeat (n) send_step();
  endtask

  // lower valid and clock the last transfer onto the scoreboard before polling the pending count
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (walk_sb.pending() != 0) @(posedge clk);
  endtask

  // start from a valid parent, then walk its children, mostly to exhaustion
  task automatic run_child_walk();
    int depth;
    int pres;
    int steps;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) depth = 0;
    else if (r < 55) depth = 1;
    else if (r < 85) depth = 2;
    else depth = $urandom_range(3, TOP_LEVEL);
    pres = $urandom_range(0, TOP_LEVEL - depth);
    send_item(KIND_START, make_parent(pres), LEVEL_W'(pres + depth), 1'($urandom));
    case (depth)
      0: steps = 1 + $urandom_range(0, 2);
      1: steps = 7 + $urandom_range(0, 2);
      2: steps = 49 + $urandom_range(0, 2);
      default: steps = $urandom_range(1, 80);
    endcase
    send_steps(steps);
  endtask

  task automatic run_bad_start();
    int pres;
    if ($urandom_range(0, 1)) begin
      send_item(KIND_START, '0, LEVEL_W'($urandom), 1'($urandom));
    end else begin
      pres = $urandom_range(1, TOP_LEVEL);
      send_item(KIND_START, make_parent(pres), LEVEL_W'($urandom_range(0, pres - 1)),
                1'($urandom));
    end
    send_steps($urandom_range(1, 3));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 5))
      send_item(1'($urandom), {$urandom, $urandom}, LEVEL_W'($urandom), 1'($urandom));
  endtask

  initial begin
    int r;
    bit pressed;
    walk_sb = new();
    pressed = 1'b0;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_START;
    item_ch.parent_index <= '0;
    item_ch.child_res <= '0;
    item_ch.pentagon_parent <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // step while null, bad starts, equal resolutions, one hexagon and one pentagon walk
    send_step();
    send_item(KIND_START, '0, 4'd9, 1'b0);
    send_item(KIND_START, make_parent(5), 4'd3, 1'b1);
    send_item(KIND_START, make_parent(TOP_LEVEL), LEVEL_W'(TOP_LEVEL), 1'b0);
    send_step();
    send_item(KIND_START, make_parent(0), 4'd0, 1'b1);
    send_step();
    send_item(KIND_START, '1, LEVEL_W'(TOP_LEVEL), 1'b1);
    send_step();
    send_item(KIND_START, make_parent(3), 4'd4, 1'b0);
    send_steps(7);
    send_item(KIND_START, make_parent(0), 4'd1, 1'b1);
    send_steps(6);

    // receiver holds off while the sender keeps offering, then the sender waits it out
    hold_off_reqs++;
    src_idle_pct = 0;
    send_item(KIND_START, make_parent(6), 4'd8, 1'b1);
    send_steps(15);
    drain_results();
    src_idle_pct = 32;

    while (walk_sb.live_items < LIVE_ITEMS) begin
      if (walk_sb.live_items < 450) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = 32;
        sink_idle_pct = 32;
      end
      if (!pressed && walk_sb.live_items > 900) begin
        pressed = 1'b1;
        hold_off_reqs++;
      end
      r = $urandom_range(0, 99);
      if (r < 75) run_child_walk();
      else if (r < 87) run_bad_start();
      else run_noise();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (walk_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
